/* hdl/bct_pkg.sv */
package bct_pkg;

    localparam int MAX_BOXES = 64;
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    localparam logic [2:0] CMD_INSERT    = 3'd0;
    localparam logic [2:0] CMD_CLEAR     = 3'd1;
    localparam logic [2:0] CMD_POINT     = 3'd2;
    localparam logic [2:0] CMD_AREA_KIND = 3'd3;
    localparam logic [2:0] CMD_AREA_ANY  = 3'd4;
    localparam logic [2:0] CMD_BOUND     = 3'd5;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    localparam logic [14:0] MAP_RESET = 15'd1024;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        size_w;
        logic [14:0]        size_h;
        logic [3:0]         kind;
        logic [15:0]        entry_id;
    } t_in_pld;

    typedef struct packed {
        logic        hit;
        logic        outside_map;
        logic [3:0]  hit_kind;
        logic [15:0] hit_id;
        logic        table_full;
    } t_out_pld;

    // item as it travels down the cell chain
    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] x_end;
        logic signed [16:0] y_end;
        logic [3:0]         kind;
        logic [15:0]        id;
        logic [CNT_W-1:0]   cnt;
        logic               hit;
        logic               outside;
        logic               full;
        logic [3:0]         hit_kind;
        logic [15:0]        hit_id;
    } t_item;

endpackage

/* hdl/bct_ifs.sv */
interface bct_in_if;
    logic             valid;
    logic             ready;
    bct_pkg::t_in_pld pld;

    modport source (output valid, output pld, input ready);
    modport sink   (input valid, input pld, output ready);
endinterface

interface bct_out_if;
    logic              valid;
    logic              ready;
    bct_pkg::t_out_pld pld;

    modport source (output valid, output pld, input ready);
    modport sink   (input valid, input pld, output ready);
endinterface

/* hdl/bct_front.sv */
module bct_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  bct_pkg::t_in_pld i_pld,
    input  logic             i_adv,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [14:0]      i_cfg_data,
    output logic             o_vld,
    output bct_pkg::t_item   o_item
);

    logic [14:0]               r_map_w;
    logic [14:0]               r_map_h;
    logic [bct_pkg::CNT_W-1:0] r_cnt;
    logic [bct_pkg::CNT_W-1:0] n_cnt;
    logic                      r_vld;
    bct_pkg::t_item            r_item;
    bct_pkg::t_item            n_item;

    logic                      xfer;
    logic                      is_full;
    logic signed [16:0]        x17;
    logic signed [16:0]        y17;
    logic signed [16:0]        xe17;
    logic signed [16:0]        ye17;
    logic                      outside;
    logic                      bound;

    assign xfer    = i_valid && i_adv;
    assign is_full = (r_cnt == bct_pkg::CNT_W'(bct_pkg::MAX_BOXES));
    assign x17     = {i_pld.pos_x[15], i_pld.pos_x};
    assign y17     = {i_pld.pos_y[15], i_pld.pos_y};
    assign xe17    = x17 + $signed({2'b00, i_pld.size_w});
    assign ye17    = y17 + $signed({2'b00, i_pld.size_h});

    assign outside = (x17 < 17'sd0) || (x17 >= $signed({2'b00, r_map_w}))
                  || (y17 < 17'sd0) || (y17 >= $signed({2'b00, r_map_h}));

    assign bound = (y17 <= 17'sd0) || (x17 <= 17'sd0)
                || ($signed({ye17[16], ye17}) >= ($signed({3'b000, r_map_h}) - 18'sd1))
                || ($signed({xe17[16], xe17}) >= ($signed({3'b000, r_map_w}) - 18'sd1));

    always_comb begin
        n_item          = '0;
        n_item.cmd      = i_pld.cmd;
        n_item.x        = x17;
        n_item.y        = y17;
        n_item.x_end    = xe17;
        n_item.y_end    = ye17;
        n_item.kind     = i_pld.kind;
        n_item.id       = i_pld.entry_id;
        n_item.cnt      = r_cnt;
        n_item.full     = (i_pld.cmd == bct_pkg::CMD_INSERT) && is_full;
        n_item.outside  = (i_pld.cmd == bct_pkg::CMD_POINT) && outside;
        n_item.hit      = n_item.outside || ((i_pld.cmd == bct_pkg::CMD_BOUND) && bound);
    end

    always_comb begin
        n_cnt = r_cnt;
        if (xfer) begin
            case (i_pld.cmd)
                bct_pkg::CMD_INSERT: if (!is_full) n_cnt = r_cnt + 1'b1;
                bct_pkg::CMD_CLEAR:  n_cnt = '0;
                default:             n_cnt = r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= bct_pkg::MAP_RESET;
            r_map_h <= bct_pkg::MAP_RESET;
            r_cnt   <= '0;
            r_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bct_pkg::REG_MAP_WIDTH:  r_map_w <= i_cfg_data;
                    bct_pkg::REG_MAP_HEIGHT: r_map_h <= i_cfg_data;
                    default:                 r_map_w <= r_map_w;
                endcase
            end
            r_cnt <= n_cnt;
            if (i_adv) r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) r_item <= n_item;
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= bct_pkg::CNT_W'(bct_pkg::MAX_BOXES))
        else $error("box count beyond table depth");

    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && (i_pld.cmd == bct_pkg::CMD_INSERT) && !is_full
        |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("insert did not advance count");

    a_full_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_item.full |-> !r_item.hit && (r_item.cmd == bct_pkg::CMD_INSERT))
        else $error("full flag on non-insert or with hit");

endmodule

/* hdl/bct_cell.sv */
module bct_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic [bct_pkg::IDX_W-1:0] i_idx,
    input  logic                      i_vld,
    input  bct_pkg::t_item            i_item,
    output logic                      o_vld,
    output bct_pkg::t_item            o_item
);

    logic signed [16:0] r_bx;
    logic signed [16:0] r_by;
    logic signed [16:0] r_bxe;
    logic signed [16:0] r_bye;
    logic [3:0]         r_kind;
    logic [15:0]        r_id;

    logic               r_vld;
    bct_pkg::t_item     r_item;
    bct_pkg::t_item     n_item;

    logic               used;
    logic               wr;
    logic               pt_hit;
    logic               area_hit;
    logic               match;

    assign used = (bct_pkg::CNT_W'(i_idx) < i_item.cnt);
    assign wr   = i_vld && i_adv && (i_item.cmd == bct_pkg::CMD_INSERT) && !i_item.full
               && (i_item.cnt[bct_pkg::IDX_W-1:0] == i_idx);

    assign pt_hit = (i_item.x >= r_bx) && (i_item.x <= r_bxe)
                 && (i_item.y >= r_by) && (i_item.y <= r_bye);

    assign area_hit = (r_bx <= i_item.x_end) && (r_bxe >= i_item.x)
                   && (r_by <= i_item.y_end) && (r_bye >= i_item.y);

    always_comb begin
        case (i_item.cmd)
            bct_pkg::CMD_POINT:     match = pt_hit;
            bct_pkg::CMD_AREA_ANY:  match = area_hit;
            bct_pkg::CMD_AREA_KIND: match = area_hit && (r_kind == i_item.kind);
            default:                match = 1'b0;
        endcase
    end

    always_comb begin
        n_item = i_item;
        if (used && !i_item.hit && match) begin
            n_item.hit      = 1'b1;
            n_item.hit_kind = r_kind;
            n_item.hit_id   = r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) r_item <= n_item;
        if (wr) begin
            r_bx   <= i_item.x;
            r_by   <= i_item.y;
            r_bxe  <= i_item.x_end;
            r_bye  <= i_item.y_end;
            r_kind <= i_item.kind;
            r_id   <= i_item.id;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

/* hdl/box_collision_table.sv */
// Each command is registered in the front stage and then in every cell of the chain before its result appears.
// Throughput: one command per cycle; each command walks a chain of one cell per
// table entry, one cell a cycle, and the whole chain stalls while the result waits.
// Reset (synchronous, active low) empties the table, sets map size to 1024 x 1024
// and drops any command in flight; box contents are not cleared.
module box_collision_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bct_in_if.sink      i_in,
    bct_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [14:0] i_cfg_data
);

    localparam int N = bct_pkg::MAX_BOXES;

    logic           adv;
    logic           w_vld  [0:N];
    bct_pkg::t_item w_item [0:N];

    assign adv        = !w_vld[N] || o_out.ready;
    assign i_in.ready = adv;

    bct_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .i_pld      (i_in.pld),
        .i_adv      (adv),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_vld      (w_vld[0]),
        .o_item     (w_item[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        bct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_idx   (bct_pkg::IDX_W'(g)),
            .i_vld   (w_vld[g]),
            .i_item  (w_item[g]),
            .o_vld   (w_vld[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    assign o_out.valid           = w_vld[N];
    assign o_out.pld.hit         = w_item[N].hit;
    assign o_out.pld.outside_map = w_item[N].outside;
    assign o_out.pld.hit_kind    = w_item[N].hit_kind;
    assign o_out.pld.hit_id      = w_item[N].hit_id;
    assign o_out.pld.table_full  = w_item[N].full;

endmodule
